>>> rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue core.
// No dependencies; imported by bdq_cell and bounded_double_ended_queue_core.
package bdq_pkg;

    // Capacity register width and its value after reset
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Width of the value field on both streams
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_LEFT  = 2'd0,
        CMD_PUSH_RIGHT = 2'd1,
        CMD_POP_LEFT   = 2'd2,
        CMD_POP_RIGHT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_PUSHED = 2'd0,
        STS_FULL   = 2'd1,
        STS_POPPED = 2'd2,
        STS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic push_left;
        logic push_right;
        logic pop_left;
        logic load_tap;
        logic shift_tap;
    } cell_ops_t;

endpackage

>>> rtl/bounded_double_ended_queue_core.sv
// Bounded double-ended queue built as a chain of shifting cells.
// Push and left pop put their result into the registered result queue; a right pop
// copies the entries into the tap line, shifts them toward cell zero and gives its
// item from tap cell zero. One item per cycle while the skid slot is free, except
// input is held off after a right pop until its item leaves the tap line. Reset clears
// count, capacity (64) and output slots; entries stay unwritten. Depends on bdq_pkg, bdq_cell.
module bounded_double_ended_queue_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // capacity register write
    input  logic                      capacity_we,
    input  logic [bdq_pkg::CAP_W-1:0] capacity_wdata,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // [31:0] push_value
    input  logic [1:0]                s_tuser,   // [1:0] command
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [31:0] data_value
    output logic [1:0]                m_tuser    // [1:0] status
);
    import bdq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    state_t                state_reg;
    state_t                state_next;
    logic [CAP_W-1:0]      capacity_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;
    logic [OCC_W-1:0]      occ_dec;

    cell_ops_t             ops;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] data_w [DEPTH];
    logic [DATA_WIDTH-1:0] tap_w  [DEPTH];

    cmd_t                  cmd;
    logic                  in_acc;
    logic                  out_acc;
    logic                  full;
    logic                  empty;

    logic                  res_wr;
    status_t               res_status;
    logic [VAL_W-1:0]      res_data;

    logic                  head_valid_reg;
    logic                  head_valid_next;
    status_t               head_status_reg;
    status_t               head_status_next;
    logic [VAL_W-1:0]      head_data_reg;
    logic [VAL_W-1:0]      head_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    status_t               skid_status_reg;
    status_t               skid_status_next;
    logic [VAL_W-1:0]      skid_data_reg;
    logic [VAL_W-1:0]      skid_data_next;

    assign cmd     = cmd_t'(s_tuser);
    assign wr_data = DATA_WIDTH'(s_tdata);
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = head_valid_reg && m_tready;
    assign occ_dec = occ_reg - OCC_W'(1);

    // Full against the capacity, saturated at the chain length
    assign full  = (CMP_W'(occ_reg) >= CMP_W'(capacity_reg)) || (occ_reg == OCC_W'(DEPTH));
    assign empty = (occ_reg == '0);

    // Take an item only while idle and the skid slot is free
    assign s_tready = (state_reg == ST_IDLE) && !skid_valid_reg;

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        logic [DATA_WIDTH-1:0] right_t;

        if (i == 0)
        begin : g_first
            assign left_d = wr_data;
        end
        else
        begin : g_inner_left
            assign left_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = data_w[i];
            assign right_t = tap_w[i];
        end
        else
        begin : g_inner_right
            assign right_d = data_w[i+1];
            assign right_t = tap_w[i+1];
        end

        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .OCC_W      (OCC_W),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ops        (ops),
            .occupancy  (occ_reg),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .right_tap  (right_t),
            .data       (data_w[i]),
            .tap        (tap_w[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd == CMD_POP_RIGHT && !empty)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cell operations, count update and result generation
    always_comb
    begin
        ops        = '0;
        occ_next   = occ_reg;
        cnt_next   = cnt_reg;
        res_wr     = 1'b0;
        res_status = STS_EMPTY;
        res_data   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_wr = 1'b1;
                    case (cmd)
                        CMD_PUSH_LEFT, CMD_PUSH_RIGHT:
                        begin
                            if (full)
                            begin
                                res_status = STS_FULL;
                            end
                            else
                            begin
                                ops.push_left  = (cmd == CMD_PUSH_LEFT);
                                ops.push_right = (cmd == CMD_PUSH_RIGHT);
                                occ_next       = occ_reg + OCC_W'(1);
                                res_status     = STS_PUSHED;
                                res_data       = VAL_W'(wr_data);
                            end
                        end
                        CMD_POP_LEFT:
                        begin
                            if (!empty)
                            begin
                                ops.pop_left = 1'b1;
                                occ_next     = occ_dec;
                                res_status   = STS_POPPED;
                                res_data     = VAL_W'(data_w[0]);
                            end
                        end
                        CMD_POP_RIGHT:
                        begin
                            if (!empty)
                            begin
                                // result leaves later from the tap line
                                res_wr       = 1'b0;
                                ops.load_tap = 1'b1;
                                occ_next     = occ_dec;
                                cnt_next     = occ_dec[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            res_wr = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    res_wr     = 1'b1;
                    res_status = STS_POPPED;
                    res_data   = VAL_W'(tap_w[0]);
                end
                else
                begin
                    ops.shift_tap = 1'b1;
                    cnt_next      = cnt_reg - IDX_W'(1);
                end
            end
            default:
            begin
                ops = '0;
            end
        endcase
    end

    // Two-slot result queue: head drives the port, skid catches overflow
    always_comb
    begin
        head_valid_next  = head_valid_reg;
        head_status_next = head_status_reg;
        head_data_next   = head_data_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        skid_data_next   = skid_data_reg;
        if (out_acc)
        begin
            head_valid_next  = skid_valid_reg;
            head_status_next = skid_status_reg;
            head_data_next   = skid_data_reg;
            skid_valid_next  = 1'b0;
        end
        if (res_wr)
        begin
            if (!head_valid_next)
            begin
                head_valid_next  = 1'b1;
                head_status_next = res_status;
                head_data_next   = res_data;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_status_next = res_status;
                skid_data_next   = res_data;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_RESET;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        head_status_reg <= head_status_next;
        head_data_reg   <= head_data_next;
        skid_status_reg <= skid_status_next;
        skid_data_reg   <= skid_data_next;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_data_reg;
    assign m_tuser  = head_status_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond chain length");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid slot filled while head slot empty");

    a_scan_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("input taken during right pop scan");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (cmd == CMD_POP_LEFT || cmd == CMD_POP_RIGHT) && occ_reg != '0) |=>
        (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("pop did not lower occupancy by one");
`endif

endmodule

>>> rtl/bdq_cell.sv
// One storage cell of the deque chain: an entry plus a tap stage used to
// carry the right end toward cell zero. Depends on bdq_pkg.
module bdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int OCC_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  bdq_pkg::cell_ops_t    ops,
    input  logic [OCC_W-1:0]      occupancy,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] right_tap,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;
    logic                  at_right_end;

    // This cell is the first free slot past the right end
    assign at_right_end = (occupancy == OCC_W'(IDX));

    // Shift or load the entry
    always_comb
    begin
        data_next = data_reg;
        if (ops.push_left)
        begin
            data_next = left_data;
        end
        else if (ops.pop_left)
        begin
            data_next = right_data;
        end
        else if (ops.push_right && at_right_end)
        begin
            data_next = wr_data;
        end
    end

    // Copy the entries into the tap line, then advance them toward cell zero
    always_comb
    begin
        tap_next = tap_reg;
        if (ops.load_tap)
        begin
            tap_next = data_reg;
        end
        else if (ops.shift_tap)
        begin
            tap_next = right_tap;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

>>> test/bounded_double_ended_queue_core_tb.sv
// Self-checking testbench for bounded_double_ended_queue_core: a directed opening, then
// random push/pop runs over several capacities, checked against an in-bench deque predictor.
// Depends on bdq_pkg and the RTL of bounded_double_ended_queue_core.
module bounded_double_ended_queue_core_tb;

    import bdq_pkg::*;

    localparam int RING_DEPTH   = 64;
    localparam int IDLE_PCT     = 17;
    localparam int STALL_LIMIT  = 3000;
    localparam int SQUEEZE_HOLD = 250;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] value;
    } deque_op_t;

    typedef struct {
        status_t     status;
        logic [31:0] value;
    } deque_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 capacity_we = 1'b0;
    logic [CAP_W-1:0]     capacity_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;    // [31:0] push_value
    logic [1:0]           s_tuser = '0;    // [1:0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;         // [31:0] data_value
    logic [1:0]           m_tuser;         // [1:0] status

    // Predictor state: ring contents, left-end pointer, fill count, capacity register
    logic [31:0]          ring_model [RING_DEPTH];
    logic [5:0]           front_model = '0;
    logic [6:0]           occ_model = '0;
    logic [CAP_W-1:0]     cap_model = CAP_RESET;

    deque_op_t            queued_ops[$];
    deque_reply_t         predicted_replies[$];
    deque_op_t            cur_op;
    deque_reply_t         want;
    int                   mismatches = 0;
    int                   idle_cycles = 0;
    int                   hold_count = 0;
    bit                   calm = 1'b0;
    bit                   squeeze = 1'b0;
    bit                   squeeze_seen = 1'b0;

    bounded_double_ended_queue_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // Apply one command to the predictor and return the reply it causes
    function automatic deque_reply_t deque_apply(input deque_op_t op);
        deque_reply_t r;
        logic [6:0]   limit;
        logic [6:0]   last;
        logic [5:0]   slot;
        limit = (cap_model > 7'(RING_DEPTH)) ? 7'(RING_DEPTH) : cap_model;
        r.value = '0;
        if (op.cmd == CMD_PUSH_LEFT || op.cmd == CMD_PUSH_RIGHT)
        begin
            if (occ_model >= limit)
            begin
                r.status = STS_FULL;
            end
            else
            begin
                if (op.cmd == CMD_PUSH_LEFT)
                begin
                    front_model = front_model - 6'd1;
                    slot = front_model;
                end
                else
                begin
                    slot = front_model + occ_model[5:0];
                end
                ring_model[slot] = op.value;
                occ_model++;
                r.status = STS_PUSHED;
                r.value = op.value;
            end
        end
        else if (occ_model == 7'd0)
        begin
            r.status = STS_EMPTY;
        end
        else
        begin
            last = occ_model - 7'd1;
            if (op.cmd == CMD_POP_LEFT)
            begin
                slot = front_model;
                front_model = front_model + 6'd1;
            end
            else
            begin
                slot = front_model + last[5:0];
            end
            r.value = ring_model[slot];
            occ_model = last;
            r.status = STS_POPPED;
        end
        return r;
    endfunction

    // Bias values toward the sign and all-ones/all-zeros corners
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic offer(input cmd_t cmd, input logic [31:0] value);
        deque_op_t op;
        op.cmd = cmd;
        op.value = value;
        queued_ops.insert(queued_ops.size(), op);
    endtask

    // Block until every queued item went in and every reply came back;
    // look between edges so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_ops.size() != 0 || s_tvalid || predicted_replies.size() != 0);
    endtask

    // Write the capacity register; only called while the block is idle
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        capacity_wdata <= value;
        capacity_we <= 1'b1;
        @(posedge clk);
        capacity_we <= 1'b0;
        cap_model = value;
    endtask

    // Fill and drain runs sized to the capacity, with a share of opposite commands
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        int  remaining;
        int  run_len;
        int  limit;
        bit  filling;
        bit  push;
        bit  right;
        remaining = count;
        limit = (cap > RING_DEPTH) ? RING_DEPTH : cap;
        wait_drained();
        set_capacity(cap);
        while (remaining > 0)
        begin
            filling = $urandom_range(1);
            run_len = $urandom_range(limit + 4, 1);
            if (run_len > remaining)
                run_len = remaining;
            for (int k = 0; k < run_len; k++)
            begin
                push = ($urandom_range(99) < 85) ? filling : !filling;
                right = $urandom_range(1);
                if (push)
                    offer(right ? CMD_PUSH_RIGHT : CMD_PUSH_LEFT, pick_value());
                else
                    offer(right ? CMD_POP_RIGHT : CMD_POP_LEFT, $urandom);
            end
            remaining -= run_len;
        end
    endtask

    // Driver: present the next item, hold it until accepted, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predicted_replies.insert(predicted_replies.size(), deque_apply(cur_op));
            if (!s_tvalid || s_tready)
            begin
                if (queued_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_op = queued_ops[0];
                    queued_ops.delete(0);
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_op.cmd;
                    s_tdata <= cur_op.value;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each reply against the oldest prediction, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    flag_mismatch($sformatf("reply with nothing pending: status %0d data %h",
                                            m_tuser, m_tdata));
                end
                else
                begin
                    want = predicted_replies[0];
                    predicted_replies.delete(0);
                    if (m_tuser !== want.status)
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                m_tuser, want.status));
                    if (m_tdata !== want.value)
                        flag_mismatch($sformatf("data %h, predicted %h", m_tdata, want.value));
                end
            end
            if (squeeze && !squeeze_seen)
            begin
                squeeze_seen = 1'b1;
                hold_count = SQUEEZE_HOLD;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pops, corner values at both ends, pops from both ends back to empty
        offer(CMD_POP_LEFT, 32'h0);
        offer(CMD_POP_RIGHT, 32'hFFFF_FFFF);
        offer(CMD_PUSH_LEFT, 32'h7FFF_FFFF);
        offer(CMD_PUSH_RIGHT, 32'h8000_0000);
        offer(CMD_PUSH_LEFT, 32'h0000_0000);
        offer(CMD_PUSH_RIGHT, 32'hFFFF_FFFF);
        offer(CMD_PUSH_LEFT, 32'h5555_5555);
        offer(CMD_PUSH_RIGHT, 32'hAAAA_AAAA);
        offer(CMD_POP_RIGHT, 32'h0);
        offer(CMD_POP_LEFT, 32'h0);
        offer(CMD_POP_RIGHT, 32'h0);
        offer(CMD_POP_LEFT, 32'h0);
        offer(CMD_POP_LEFT, 32'h0);
        offer(CMD_POP_RIGHT, 32'h0);
        offer(CMD_POP_LEFT, 32'h0);

        // Zero capacity refuses every push
        wait_drained();
        set_capacity(7'd0);
        offer(CMD_PUSH_LEFT, 32'h1234_5678);
        offer(CMD_PUSH_RIGHT, 32'h8765_4321);
        offer(CMD_POP_RIGHT, 32'h0);

        // Lower capacity below the fill level: entries stay, pushes refused, pops work
        wait_drained();
        set_capacity(7'd6);
        offer(CMD_PUSH_RIGHT, 32'h0000_0011);
        offer(CMD_PUSH_RIGHT, 32'h0000_0022);
        offer(CMD_PUSH_RIGHT, 32'h0000_0033);
        offer(CMD_PUSH_RIGHT, 32'h0000_0044);
        wait_drained();
        set_capacity(7'd2);
        offer(CMD_PUSH_LEFT, 32'hDEAD_BEEF);
        offer(CMD_POP_LEFT, 32'h0);
        offer(CMD_POP_RIGHT, 32'h0);
        offer(CMD_PUSH_RIGHT, 32'hCAFE_F00D);
        offer(CMD_POP_LEFT, 32'h0);

        // Random runs over a range of capacities, the first without idling
        calm = 1'b1;
        run_phase(7'd64, 120);
        wait_drained();
        calm = 1'b0;
        run_phase(7'd1, 100);
        // Hold the receiver off while pushes keep coming
        wait_drained();
        squeeze = 1'b1;
        run_phase(7'd127, 160);
        run_phase(7'd0, 40);
        run_phase(7'd2, 100);
        run_phase(7'd5, 120);
        run_phase(7'd64, 180);
        run_phase(7'd17, 120);
        run_phase(7'($urandom_range(64, 1)), 120);
        run_phase(7'd3, 100);
        run_phase(7'($urandom_range(127)), 100);

        // Let any stray reply show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
